// ===== src/b2d_pkg.sv =====
package b2d_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_BITS = 32;
  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);
  localparam int REM_W = $clog2(NUM_DIGITS);

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } b2d_cell_ctrl_t;

endpackage

// ===== src/b2d_cell.sv =====
module b2d_cell (
  input  logic                    clk,
  input  b2d_pkg::b2d_cell_ctrl_t ctrl,
  input  logic                    bit_in,
  input  b2d_pkg::digit_t         digit_in,
  output logic                    bit_out,
  output b2d_pkg::digit_t         digit
);
  import b2d_pkg::*;

  digit_t corr;

  always_comb begin
    corr    = (digit >= 4'd5) ? digit + 4'd3 : digit;
    bit_out = corr[3];
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.dabble) begin
      digit <= {corr[2:0], bit_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end
  end

endmodule

// ===== src/binary_to_decimal_ascii_top.sv =====
// Converts one unsigned binary number per request into its decimal ASCII digits, most
// significant first, leading zeros dropped, with last set on the final digit; zero gives a
// single '0'. A row of BCD digit cells does serial double dabble: a load step, then one
// dabble step per value bit (32 at the default width), then one step per digit position
// (10 at the default width), in which leading zeros are skipped and real digits go out;
// each digit position waits while the output is stalled. in_stall is high for the whole
// conversion. The output register lets the final digit wait while the next request is
// taken.
module binary_to_decimal_ascii_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2d_pkg::IN_BITS-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    digit_char,
  output logic                          last
);
  import b2d_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DABBLE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [REM_W-1:0]      rem;
  logic                  started;
  logic [VALUE_BITS-1:0] bin;
  logic [63:0]           value_wide;
  logic                  out_free;
  logic                  is_last;
  digit_t                top_digit;
  b2d_cell_ctrl_t        ctrl;

  logic   carry  [NUM_DIGITS];
  digit_t digits [NUM_DIGITS];

  assign value_wide = {{(64 - IN_BITS){1'b0}}, value};
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign top_digit  = digits[NUM_DIGITS-1];
  assign is_last    = (rem == '0);

  always_comb begin
    ctrl.clear  = (state == ST_IDLE) && in_valid;
    ctrl.dabble = (state == ST_DABBLE);
    ctrl.move   = (state == ST_EMIT) && out_free;
  end

  assign carry[0] = bin[VALUE_BITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == NUM_DIGITS - 1) begin : g_top
      b2d_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i]),
        .digit_in (digits[i-1]),
        .bit_out  (),
        .digit    (digits[i])
      );
    end else if (i == 0) begin : g_low
      b2d_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i]),
        .digit_in (4'd0),
        .bit_out  (carry[i+1]),
        .digit    (digits[i])
      );
    end else begin : g_mid
      b2d_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i]),
        .digit_in (digits[i-1]),
        .bit_out  (carry[i+1]),
        .digit    (digits[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      rem       <= '0;
      started   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            bin   <= value_wide[VALUE_BITS-1:0];
            cnt   <= CNT_W'(VALUE_BITS - 1);
            state <= ST_DABBLE;
          end
        end
        ST_DABBLE: begin
          bin <= {bin[VALUE_BITS-2:0], 1'b0};
          if (cnt == '0) begin
            rem     <= REM_W'(NUM_DIGITS - 1);
            started <= 1'b0;
            state   <= ST_EMIT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (top_digit != 4'd0 || started || is_last) begin
              out_valid  <= 1'b1;
              digit_char <= {2'b11, top_digit};
              last       <= is_last;
              started    <= 1'b1;
            end
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              rem <= rem - REM_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/b2d_checker.sv =====
module b2d_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] digit_char,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last))
    else $error("stalled result changed");

  a_digit_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9)
    else $error("result is not a decimal digit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while converting");

  a_busy_mid_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("new request taken before final digit");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset left block busy");

endmodule

bind binary_to_decimal_ascii_top b2d_checker u_b2d_checker (.*);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b2d_pkg::*;

  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam int unsigned RADIX = 10;

  typedef struct {
    logic [5:0] ch;
    logic       is_last;
  } ascii_digit_t;

  class decimal_digit_board;
    ascii_digit_t expected_digits[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    function void note_value(logic [IN_BITS-1:0] v);
      logic [63:0] rest;
      logic [3:0] rev[$];
      ascii_digit_t d;
      rest = 64'(v);
      if (VALUE_BITS < 64) begin
        rest = rest & ((64'd1 << VALUE_BITS) - 64'd1);
      end
      do begin
        rev.push_back(4'(rest % RADIX));
        rest = rest / RADIX;
      end while (rest != 0);
      for (int k = rev.size() - 1; k >= 0; k--) begin
        d.ch = (6'(rev[k]) + ASCII_ZERO) & 6'h3F;
        d.is_last = (k == 0);
        expected_digits.push_back(d);
      end
    endfunction

    function void check_digit(logic [5:0] ch, logic lst);
      ascii_digit_t d;
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit: expected none actual char %0d last %0b",
                 $time, ch, lst);
        errors++;
        return;
      end
      d = expected_digits.pop_front();
      if (ch !== d.ch) begin
        $display("%0t: digit_char mismatch: expected %0d actual %0d", $time, d.ch, ch);
        errors++;
      end
      if (lst !== d.is_last) begin
        $display("%0t: last mismatch: expected %0b actual %0b", $time, d.is_last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [IN_BITS-1:0]  value;
  logic                out_valid;
  logic                out_stall;
  logic [5:0]          digit_char;
  logic                last;

  logic send_idle;
  logic recv_idle;
  decimal_digit_board board;

  binary_to_decimal_ascii_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic send_value(logic [IN_BITS-1:0] v);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_stall);
    board.note_value(v);
  endtask

  task automatic wait_for_digits();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] power_of_ten(int k);
    logic [31:0] p;
    p = 32'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 32'd10;
    end
    return p;
  endfunction

  function automatic logic [IN_BITS-1:0] random_value();
    int sel;
    int k;
    logic [31:0] lo;
    logic [31:0] hi;
    sel = $urandom_range(0, 9);
    k = $urandom_range(1, 10);
    case (sel)
      0, 1, 2: return $urandom();
      3: return $urandom() >> $urandom_range(0, 31);
      4: begin
        lo = power_of_ten(k - 1);
        return (k == 10) ? lo : lo + $urandom_range(0, 1) - ((k > 1) ? 32'd0 : 32'd0);
      end
      5: return power_of_ten(k - 1) - 32'd1 + ((k == 1) ? 32'd1 : 32'd0);
      6: return $urandom_range(0, 9);
      default: begin
        lo = power_of_ten(k - 1);
        hi = (k == 10) ? 32'hFFFF_FFFF : power_of_ten(k) - 32'd1;
        return $urandom_range(hi, lo);
      end
    endcase
  endfunction

  // result side: random stall per digit, stall-free stretches when recv_idle is low
  initial begin
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = recv_idle ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_digit(digit_char, last);
    end
  end

  initial begin
    logic [IN_BITS-1:0] directed[$];
    board = new();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd12345,
                 32'd999999999, 32'd1000000000, 32'd1000000001, 32'd2147483647,
                 32'd2147483648, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'd0, 32'd4000000000, 32'd100000, 32'd7};
    foreach (directed[i]) begin
      send_value(directed[i]);
    end

    // hold off until every digit is out
    wait_for_digits();

    for (int i = 0; i < 480; i++) begin
      if (i == 120) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if (i == 240) begin
        wait_for_digits();
        send_idle = 1'b1;
        recv_idle = 1'b0;
      end else if (i == 360) begin
        send_idle = 1'b0;
        recv_idle = 1'b1;
      end else if (i == 420) begin
        send_idle = 1'b1;
      end
      send_value(random_value());
    end

    wait_for_digits();
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d digits outstanding", $time, board.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
